FILE: hw/rtl/wbc_pkg.sv
// shared types, constants and helpers for the windowed burst counter
`default_nettype none

package wbc_pkg;

	// field widths
	localparam int unsigned CARD_W   = 63;
	localparam int unsigned TIME_W   = 40;
	localparam int unsigned TOTAL_W  = 32;
	localparam int unsigned WIN_W    = 32;
	localparam int unsigned THR_W    = 7;
	// wide enough for the occupancy at the largest window depth
	localparam int unsigned ACC_W    = 13;
	// configuration port
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned APB_AW   = 3;

	// register indexes (address bit 2)
	localparam logic REG_WINDOW    = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	// reset values of the registers
	localparam logic [WIN_W-1:0] WINDOW_RESET    = 32'd300;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 7'd3;

	typedef struct packed {
		logic [CARD_W-1:0] card_number;
		logic [TIME_W-1:0] event_time;
		logic              end_of_data;
	} item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] suspicious_total;
		logic               total_final;
	} result_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_seconds;
		logic [THR_W-1:0] count_threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_READ,
		ST_CHECK,
		ST_PUSH,
		ST_END,
		ST_EMIT
	} eng_state_t;

	// saturating add of a small count onto the running total
	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [ACC_W-1:0] k);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, a} + (TOTAL_W+1)'(k);
		return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wbc_cfg_regs.sv
// configuration registers behind the apb-style port
`default_nettype none

module wbc_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [wbc_pkg::APB_AW-1:0] paddr,
	input  wire logic [wbc_pkg::APB_DW-1:0] pwdata,
	output logic      [wbc_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output wbc_pkg::cfg_t                   cfg
);

	logic [wbc_pkg::WIN_W-1:0] window_q;
	logic [wbc_pkg::THR_W-1:0] threshold_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= wbc_pkg::WINDOW_RESET;
			threshold_q <= wbc_pkg::THRESHOLD_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				wbc_pkg::REG_WINDOW:    window_q    <= pwdata[wbc_pkg::WIN_W-1:0];
				wbc_pkg::REG_THRESHOLD: threshold_q <= pwdata[wbc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			wbc_pkg::REG_WINDOW:    prdata = window_q;
			wbc_pkg::REG_THRESHOLD: prdata = wbc_pkg::APB_DW'(threshold_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.window_seconds  = window_q;
	assign cfg.count_threshold = threshold_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wbc_fifo.sv
// two-entry word queue between the front, the engine and the result side
`default_nettype none

module wbc_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/wbc_engine.sv
// back end: window fifo of start times, head retirement, flush and scoring
`default_nettype none

module wbc_engine #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire wbc_pkg::cfg_t   cfg,
	input  wire wbc_pkg::item_t  in_item,
	input  wire logic            in_empty,
	output logic                 in_pop,
	input  wire logic            out_full,
	output logic                 out_push,
	output wbc_pkg::result_t     out_result
);

	localparam int unsigned HEAD_W = $clog2(DEPTH);
	localparam int unsigned OCC_W  = $clog2(DEPTH + 1);

	wbc_pkg::eng_state_t state_q, state_d;

	logic [wbc_pkg::TIME_W-1:0]  mem [DEPTH];
	logic [wbc_pkg::TIME_W-1:0]  rd_q;
	logic [HEAD_W-1:0]           head_q;
	logic [OCC_W-1:0]            occ_q;
	logic [wbc_pkg::CARD_W-1:0]  card_q;
	logic                        card_valid_q;
	logic [wbc_pkg::TOTAL_W-1:0] total_q;

	logic [wbc_pkg::THR_W-1:0]   thr;
	logic [wbc_pkg::ACC_W-1:0]   occ_ext;
	logic [wbc_pkg::ACC_W-1:0]   thr_ext;
	logic                        scores;
	logic [wbc_pkg::ACC_W-1:0]   flush_k;
	logic [HEAD_W-1:0]           head_inc;
	logic [OCC_W:0]              tail_sum;
	logic [HEAD_W-1:0]           tail;
	logic                        fifo_full;
	logic                        card_change;
	logic                        expired;
	logic                        rd_en;
	logic                        wr_en;
	logic [HEAD_W-1:0]           wr_addr;

	// threshold of zero behaves as one
	assign thr     = (cfg.count_threshold == '0) ? wbc_pkg::THR_W'(1) : cfg.count_threshold;
	assign occ_ext = wbc_pkg::ACC_W'(occ_q);
	assign thr_ext = wbc_pkg::ACC_W'(thr);
	assign scores  = occ_ext >= thr_ext;
	assign flush_k = scores ? (occ_ext - thr_ext + wbc_pkg::ACC_W'(1)) : '0;

	// ring arithmetic, depth need not be a power of two
	assign head_inc = (head_q == HEAD_W'(DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);
	assign tail_sum = (OCC_W+1)'(head_q) + (OCC_W+1)'(occ_q);
	assign tail     = (tail_sum >= (OCC_W+1)'(DEPTH)) ?
		HEAD_W'(tail_sum - (OCC_W+1)'(DEPTH)) : HEAD_W'(tail_sum);
	assign fifo_full = occ_q == OCC_W'(DEPTH);

	assign card_change = card_valid_q && (in_item.card_number != card_q);
	// head plus window below the new time, without wrap
	assign expired = ({1'b0, rd_q} + (wbc_pkg::TIME_W+1)'(cfg.window_seconds))
		< {1'b0, in_item.event_time};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wbc_pkg::ST_WAIT:  if (!in_empty) state_d = wbc_pkg::ST_READ;
			wbc_pkg::ST_READ:  state_d = (occ_q == '0) ? wbc_pkg::ST_PUSH : wbc_pkg::ST_CHECK;
			wbc_pkg::ST_CHECK: state_d = expired ? wbc_pkg::ST_READ : wbc_pkg::ST_PUSH;
			wbc_pkg::ST_PUSH:  state_d = wbc_pkg::ST_END;
			wbc_pkg::ST_END:   state_d = wbc_pkg::ST_EMIT;
			wbc_pkg::ST_EMIT:  if (!out_full) state_d = wbc_pkg::ST_WAIT;
			default:           state_d = wbc_pkg::ST_WAIT;
		endcase
	end

	// outputs and memory strobes
	always_comb begin
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = tail;
		in_pop   = 1'b0;
		out_push = 1'b0;
		unique case (state_q)
			wbc_pkg::ST_READ: rd_en = occ_q != '0;
			wbc_pkg::ST_PUSH: begin
				wr_en   = 1'b1;
				wr_addr = fifo_full ? head_q : tail;
			end
			wbc_pkg::ST_EMIT: begin
				in_pop   = ~out_full;
				out_push = ~out_full;
			end
			default: ;
		endcase
	end

	assign out_result.suspicious_total = total_q;
	assign out_result.total_final      = in_item.end_of_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_item.event_time;
		end
		if (rd_en) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbc_pkg::ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	// window state and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			occ_q        <= '0;
			card_q       <= '0;
			card_valid_q <= 1'b0;
			total_q      <= '0;
		end else begin
			case (state_q)
				wbc_pkg::ST_WAIT: begin
					if (!in_empty) begin
						if (card_change) begin
							total_q <= wbc_pkg::sat_add(total_q, flush_k);
							occ_q   <= '0;
							head_q  <= '0;
						end
						card_q       <= in_item.card_number;
						card_valid_q <= 1'b1;
					end
				end
				wbc_pkg::ST_CHECK: begin
					if (expired) begin
						total_q <= wbc_pkg::sat_add(total_q, wbc_pkg::ACC_W'(scores));
						head_q  <= head_inc;
						occ_q   <= occ_q - OCC_W'(1);
					end
				end
				wbc_pkg::ST_PUSH: begin
					// full window: the head goes early and the slot is reused
					if (fifo_full) begin
						total_q <= wbc_pkg::sat_add(total_q, wbc_pkg::ACC_W'(scores));
						head_q  <= head_inc;
					end else begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				wbc_pkg::ST_END: begin
					if (in_item.end_of_data) begin
						total_q      <= wbc_pkg::sat_add(total_q, flush_k);
						occ_q        <= '0;
						head_q       <= '0;
						card_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/windowed_burst_counter.sv
// top level of the windowed burst counter
//
//  channel  direction  handshake        payload
//  events   in         push / full      card_number, event_time, end_of_data
//  results  out        empty / pop      suspicious_total, total_final
//  config   in         apb psel/penable window_seconds (0x0), count_threshold (0x4)
//
// each word passes the wait, read, push, end and emit states, plus a check state
// when the window is not empty and a read and check for every head that leaves
// it: a retirement loop over the start-time memory, one registered read per head.
// two-word queues sit in front of and behind the engine, so a stalled pop
// does not block pushes until both queues fill.
// reset clears all control state; the start-time memory is not cleared.
`default_nettype none

module windowed_burst_counter #(
	parameter int unsigned WINDOW_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [wbc_pkg::CARD_W-1:0]       card_number,
	input  wire logic [wbc_pkg::TIME_W-1:0]       event_time,
	input  wire logic                             end_of_data,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic      [wbc_pkg::TOTAL_W-1:0]      suspicious_total,
	output logic                                  total_final,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [wbc_pkg::APB_AW-1:0]       paddr,
	input  wire logic [wbc_pkg::APB_DW-1:0]       pwdata,
	output logic      [wbc_pkg::APB_DW-1:0]       prdata,
	output logic                                  pready
);

	localparam int unsigned ITEM_W = $bits(wbc_pkg::item_t);
	localparam int unsigned RES_W  = $bits(wbc_pkg::result_t);

	wbc_pkg::cfg_t    cfg;
	wbc_pkg::item_t   in_word;
	wbc_pkg::item_t   eng_item;
	wbc_pkg::result_t eng_result;
	wbc_pkg::result_t res_word;
	logic [ITEM_W-1:0] eng_item_bits;
	logic [RES_W-1:0]  res_bits;
	logic              in_empty;
	logic              in_pop;
	logic              res_full;
	logic              res_push;

	assign in_word.card_number = card_number;
	assign in_word.event_time  = event_time;
	assign in_word.end_of_data = end_of_data;

	// configuration registers
	wbc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front queue of incoming words
	wbc_fifo #(.WIDTH(ITEM_W)) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_word),
		.full    (full),
		.rd_en   (in_pop),
		.rd_data (eng_item_bits),
		.empty   (in_empty)
	);

	assign eng_item = wbc_pkg::item_t'(eng_item_bits);

	// window engine
	wbc_engine #(.DEPTH(WINDOW_DEPTH)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_item    (eng_item),
		.in_empty   (in_empty),
		.in_pop     (in_pop),
		.out_full   (res_full),
		.out_push   (res_push),
		.out_result (eng_result)
	);

	// result queue
	wbc_fifo #(.WIDTH(RES_W)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (eng_result),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_bits),
		.empty   (empty)
	);

	assign res_word         = wbc_pkg::result_t'(res_bits);
	assign suspicious_total = res_word.suspicious_total;
	assign total_final      = res_word.total_final;

	// engine never pushes into a full result queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("engine pushed into a full result queue");

	// a word is retired from the front only when it is there
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |-> !in_empty)
		else $error("engine popped an empty front queue");

	// each result leaves together with its own event word
	a_pop_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		res_push == in_pop)
		else $error("result push and event pop out of step");

	// a pushed result is visible on the next cycle
	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("pushed result not visible");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for the windowed burst counter: directed and random traffic against a running score model
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 64;
	localparam logic [wbc_pkg::APB_AW-1:0] ADDR_WINDOW    = {wbc_pkg::REG_WINDOW, 2'b00};
	localparam logic [wbc_pkg::APB_AW-1:0] ADDR_THRESHOLD = {wbc_pkg::REG_THRESHOLD, 2'b00};
	localparam logic [wbc_pkg::CARD_W-1:0] CARD_MAX = '1;
	localparam logic [wbc_pkg::TIME_W-1:0] TIME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        push = 1'b0;
	logic                        full;
	logic [wbc_pkg::CARD_W-1:0]  card_number = '0;
	logic [wbc_pkg::TIME_W-1:0]  event_time = '0;
	logic                        end_of_data = 1'b0;
	logic                        empty;
	logic                        pop = 1'b0;
	logic [wbc_pkg::TOTAL_W-1:0] suspicious_total;
	logic                        total_final;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [wbc_pkg::APB_AW-1:0]  paddr = '0;
	logic [wbc_pkg::APB_DW-1:0]  pwdata = '0;
	logic [wbc_pkg::APB_DW-1:0]  prdata;
	logic                        pready;

	windowed_burst_counter #(.WINDOW_DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.card_number(card_number),
		.event_time(event_time),
		.end_of_data(end_of_data),
		.empty(empty),
		.pop(pop),
		.suspicious_total(suspicious_total),
		.total_final(total_final),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// words waiting to be sent and totals waiting to come back
	wbc_pkg::item_t   event_q[$];
	wbc_pkg::result_t total_q[$];
	int      items_added = 0;
	int      items_accepted = 0;
	int      errors = 0;

	// mirror of the registers
	logic [wbc_pkg::WIN_W-1:0] cfg_window = wbc_pkg::WINDOW_RESET;
	logic [wbc_pkg::THR_W-1:0] cfg_threshold = wbc_pkg::THRESHOLD_RESET;

	// mirror of the start-time window and the running score
	logic [wbc_pkg::TIME_W-1:0]  win_mem [DEPTH];
	int unsigned                 win_head = 0;
	int unsigned                 win_count = 0;
	logic [wbc_pkg::CARD_W-1:0]  held_card = '0;
	logic                        held_valid = 1'b0;
	logic [wbc_pkg::TOTAL_W-1:0] tally = '0;

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic void tally_add(input int unsigned k);
		logic [wbc_pkg::TOTAL_W:0] sum;
		sum = {1'b0, tally} + (wbc_pkg::TOTAL_W+1)'(k);
		tally = sum[wbc_pkg::TOTAL_W] ? '1 : sum[wbc_pkg::TOTAL_W-1:0];
	endfunction

	function automatic void retire_oldest(input int unsigned thr);
		if (win_count >= thr)
			tally_add(1);
		win_head = (win_head + 1) % DEPTH;
		win_count--;
	endfunction

	// every start still pending that has enough followers scores at once
	function automatic void flush_window(input int unsigned thr);
		if (win_count >= thr)
			tally_add(win_count - thr + 1);
		win_count = 0;
		win_head = 0;
	endfunction

	function automatic wbc_pkg::result_t score_event(input wbc_pkg::item_t ev);
		int unsigned      thr;
		wbc_pkg::result_t r;
		thr = (cfg_threshold == '0) ? 1 : int'(cfg_threshold);
		// a new card closes the old one
		if (held_valid && ev.card_number != held_card)
			flush_window(thr);
		held_card = ev.card_number;
		held_valid = 1'b1;
		// retire heads that have fallen out of the window, no wrap on the sum
		while (win_count > 0 && ({24'b0, win_mem[win_head]} + {32'b0, cfg_window})
				< {24'b0, ev.event_time})
			retire_oldest(thr);
		// full window gives up its head early
		if (win_count >= DEPTH)
			retire_oldest(thr);
		win_mem[(win_head + win_count) % DEPTH] = ev.event_time;
		win_count++;
		if (ev.end_of_data) begin
			flush_window(thr);
			held_valid = 1'b0;
		end
		r.suspicious_total = tally;
		r.total_final = ev.end_of_data;
		return r;
	endfunction

	// idle draw: long calm stretches with no gaps at all
	bit send_calm = 1'b0;
	bit pop_calm = 1'b0;
	int send_gap = 0;
	int pop_gap = 0;

	// driver: one word per push handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				total_q.push_back(score_event(event_q.pop_front()));
				items_accepted++;
				if ($urandom_range(0, 49) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 6);
			end
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (event_q.size() > 0) begin
					push <= 1'b1;
					card_number <= event_q[0].card_number;
					event_time <= event_q[0].event_time;
					end_of_data <= event_q[0].end_of_data;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each popped word with the oldest expected total
	always @(posedge clk) begin
		wbc_pkg::result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (total_q.size() == 0) begin
					note_error($sformatf("unexpected word: total %0d final %0b",
						suspicious_total, total_final));
				end else begin
					want = total_q.pop_front();
					if (suspicious_total !== want.suspicious_total)
						note_error($sformatf("suspicious_total: expected %0d got %0d",
							want.suspicious_total, suspicious_total));
					if (total_final !== want.total_final)
						note_error($sformatf("total_final: expected %0b got %0b",
							want.total_final, total_final));
				end
				if ($urandom_range(0, 49) == 0)
					pop_calm = !pop_calm;
				pop_gap = pop_calm ? 0 : $urandom_range(0, 6);
			end
			if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic add_event(input logic [wbc_pkg::CARD_W-1:0] card,
			input logic [wbc_pkg::TIME_W-1:0] t, input logic last);
		wbc_pkg::item_t ev;
		ev.card_number = card;
		ev.event_time = t;
		ev.end_of_data = last;
		event_q.push_back(ev);
		items_added++;
	endtask

	task automatic wait_idle();
		while (items_accepted != items_added || total_q.size() != 0)
			@(posedge clk);
	endtask

	// one apb transfer; reads are checked against the register mirror
	task automatic apb_access(input logic wr, input logic [wbc_pkg::APB_AW-1:0] addr,
			input logic [wbc_pkg::APB_DW-1:0] data);
		logic [wbc_pkg::APB_DW-1:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr) begin
			if (addr == ADDR_WINDOW)
				cfg_window = data;
			else
				cfg_threshold = data[wbc_pkg::THR_W-1:0];
		end else begin
			want = (addr == ADDR_WINDOW) ? cfg_window : wbc_pkg::APB_DW'(cfg_threshold);
			if (prdata !== want)
				note_error($sformatf("register 0x%0h read: expected %0d got %0d",
					addr, want, prdata));
		end
	endtask

	task automatic program_window(input logic [wbc_pkg::WIN_W-1:0] w,
			input logic [wbc_pkg::THR_W-1:0] thr);
		wait_idle();
		apb_access(1'b1, ADDR_WINDOW, w);
		apb_access(1'b1, ADDR_THRESHOLD, wbc_pkg::APB_DW'(thr));
		apb_access(1'b0, ADDR_WINDOW, '0);
		apb_access(1'b0, ADDR_THRESHOLD, '0);
	endtask

	// mostly well-formed cards in time order, some dense enough to fill the window
	task automatic make_traffic(input int n);
		logic [wbc_pkg::CARD_W-1:0] card;
		logic [wbc_pkg::TIME_W-1:0] t;
		logic [31:0]                stride;
		logic                       last;
		int                         left;
		int                         run_len;
		int                         k;
		int                         i;
		bit                         dense;
		left = n;
		while (left > 0) begin
			card = wbc_pkg::CARD_W'({$urandom, $urandom});
			k = $urandom_range(0, 15);
			if (k == 0)
				card = '0;
			else if (k == 1)
				card = CARD_MAX;
			t = {8'($urandom), 32'($urandom)};
			dense = ($urandom_range(0, 4) == 0);
			run_len = dense ? $urandom_range(40, 90) : $urandom_range(1, 20);
			stride = cfg_window >> 3;
			if (stride > 32'd1048576)
				stride = 32'd1048576;
			for (i = 0; i < run_len && left > 0; i++) begin
				k = $urandom_range(0, 31);
				// noise: time stepping back, or a jump clear of the window
				if (k == 0)
					t = t - wbc_pkg::TIME_W'($urandom_range(0, 50));
				else if (k < 4 && !dense)
					t = t + wbc_pkg::TIME_W'(cfg_window)
						+ wbc_pkg::TIME_W'($urandom_range(1, 1000));
				else if (dense)
					t = t + wbc_pkg::TIME_W'($urandom_range(0, stride >> 4));
				else
					t = t + wbc_pkg::TIME_W'($urandom_range(0, 2 * stride));
				last = (i == run_len - 1 && $urandom_range(0, 3) == 0)
					|| $urandom_range(0, 79) == 0 || left == 1;
				add_event(card, t, last);
				left--;
			end
		end
	endtask

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// registers come up at their reset values
		apb_access(1'b0, ADDR_WINDOW, '0);
		apb_access(1'b0, ADDR_THRESHOLD, '0);

		// directed: default window, first card is card zero
		program_window(32'd300, 7'd3);
		add_event('0, 40'd0, 1'b0);
		add_event('0, 40'd10, 1'b0);
		add_event('0, 40'd20, 1'b0);
		add_event('0, 40'd400, 1'b0);
		add_event('0, 40'd350, 1'b0);
		add_event(CARD_MAX, 40'd0, 1'b0);
		add_event(CARD_MAX, TIME_MAX, 1'b0);
		add_event(CARD_MAX, TIME_MAX, 1'b1);
		add_event(CARD_MAX, 40'd5, 1'b0);
		add_event(63'd5, 40'd5, 1'b1);

		// directed: zero window, equal and backward times
		program_window(32'd0, 7'd1);
		add_event(63'd7, 40'd100, 1'b0);
		add_event(63'd7, 40'd100, 1'b0);
		add_event(63'd7, 40'd100, 1'b0);
		add_event(63'd7, 40'd101, 1'b0);
		add_event(63'd7, 40'd99, 1'b0);
		add_event(63'd7, 40'd101, 1'b1);

		// directed: widest window with a zero threshold
		program_window('1, 7'd0);
		add_event(63'd9, 40'd0, 1'b0);
		add_event(63'd9, 40'hFF_FFFF_FFFF >> 8, 1'b0);
		add_event(63'd9, 40'h01_0000_0000, 1'b0);
		add_event(63'd9, TIME_MAX, 1'b0);
		add_event(63'd1, TIME_MAX, 1'b0);
		add_event(63'd2, 40'd0, 1'b1);

		// random phases across several register settings
		program_window(32'd300, 7'd3);
		make_traffic(300);
		program_window(32'd0, 7'd1);
		make_traffic(300);
		program_window('1, 7'd64);
		make_traffic(300);
		program_window(wbc_pkg::WIN_W'($urandom_range(1, 5000)),
			wbc_pkg::THR_W'($urandom_range(1, 64)));
		make_traffic(300);
		program_window(32'd60, 7'd2);
		make_traffic(300);
		program_window(wbc_pkg::WIN_W'($urandom), wbc_pkg::THR_W'($urandom_range(32, 64)));
		make_traffic(300);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("windowed_burst_counter verification clean");
		else
			$display("windowed_burst_counter verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("windowed_burst_counter verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/wbc_pkg.sv
hw/rtl/wbc_cfg_regs.sv
hw/rtl/wbc_fifo.sv
hw/rtl/wbc_engine.sv
hw/rtl/windowed_burst_counter.sv
tb/sv/tb_top.sv
